@@ hw/rtl/jpm_pkg.sv @@
// jpm_pkg: shared types, constants and microcode table for the joystick pointer mover
// used by jpm_seq, joystick_pointer_mover_core and jpm_checker; no dependencies
`default_nettype none

package jpm_pkg;

  // channel and register widths
  localparam int IN_W       = 40;  // axis_x, axis_y, button_a, button_b, zero fill
  localparam int OUT_W      = 56;  // seven result fields, zero fill
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;

  // register reset values
  localparam logic [14:0] DEADZONE_RST   = 15'd4915;
  localparam logic [15:0] SPEED_SLOW_RST = 16'd1024;
  localparam logic [15:0] SPEED_FAST_RST = 16'd5120;
  localparam logic [12:0] VIEW_W_RST     = 13'd800;
  localparam logic [12:0] VIEW_H_RST     = 13'd600;
  localparam logic [7:0]  MOVE_LIM_RST   = 8'd4;
  localparam logic [7:0]  HOVER_DLY_RST  = 8'd16;

  // state reset values, Q13.8 position
  localparam logic [20:0] POS_X_RST = 21'(400 * 256);
  localparam logic [20:0] POS_Y_RST = 21'(300 * 256);

  // arithmetic constants
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [15:0] DECAY_Q16 = 16'd36045;  // 0.55
  localparam logic [16:0] SNAP_Q8   = 17'd128;    // 0.5 pixel

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE   = 3'd0,
    REG_SPEED_SLOW = 3'd1,
    REG_SPEED_FAST = 3'd2,
    REG_VIEW_W     = 3'd3,
    REG_VIEW_H     = 3'd4,
    REG_MOVE_LIM   = 3'd5,
    REG_HOVER_DLY  = 3'd6
  } cfg_reg_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_MX_MX  = 3'd0,
    MUL_MY_MY  = 3'd1,
    MUL_D_M2   = 3'd2,
    MUL_MX_SPD = 3'd3,
    MUL_MY_SPD = 3'd4,
    MUL_VX_DEC = 3'd5,
    MUL_VY_DEC = 3'd6,
    MUL_NONE   = 3'd7
  } mul_sel_t;

  // datapath register load per step
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_LD_ACC  = 4'd1,
    OP_ADD_ACC = 4'd2,
    OP_LD_SPD  = 4'd3,
    OP_VX_LIVE = 4'd4,
    OP_VY_LIVE = 4'd5,
    OP_VX_DEC  = 4'd6,
    OP_VY_DEC  = 4'd7,
    OP_MOVE    = 4'd8,
    OP_FINISH  = 4'd9
  } dp_op_t;

  // jump condition
  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_IDLE   = 2'd1,  // taken when neither axis is live
    JMP_ALWAYS = 2'd2
  } jmp_t;

  typedef struct packed {
    mul_sel_t          mul;
    dp_op_t            op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic live;  // an axis is outside the deadzone
    logic hold;  // result register still occupied
  } seq_status_t;

  localparam logic [STEP_W-1:0] L_DECAY = 4'd8;
  localparam logic [STEP_W-1:0] L_MOVE  = 4'd11;

  // microcode program
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{mul: MUL_NONE, op: OP_NOP, jmp: JMP_NEXT, target: '0};
    case (step)
      4'd0:  w = '{mul: MUL_MX_MX,  op: OP_NOP,     jmp: JMP_IDLE,   target: L_DECAY};
      4'd1:  w = '{mul: MUL_MY_MY,  op: OP_LD_ACC,  jmp: JMP_NEXT,   target: '0};
      4'd2:  w = '{mul: MUL_NONE,   op: OP_ADD_ACC, jmp: JMP_NEXT,   target: '0};
      4'd3:  w = '{mul: MUL_D_M2,   op: OP_NOP,     jmp: JMP_NEXT,   target: '0};
      4'd4:  w = '{mul: MUL_NONE,   op: OP_LD_SPD,  jmp: JMP_NEXT,   target: '0};
      4'd5:  w = '{mul: MUL_MX_SPD, op: OP_NOP,     jmp: JMP_NEXT,   target: '0};
      4'd6:  w = '{mul: MUL_MY_SPD, op: OP_VX_LIVE, jmp: JMP_NEXT,   target: '0};
      4'd7:  w = '{mul: MUL_NONE,   op: OP_VY_LIVE, jmp: JMP_ALWAYS, target: L_MOVE};
      4'd8:  w = '{mul: MUL_VX_DEC, op: OP_NOP,     jmp: JMP_NEXT,   target: '0};
      4'd9:  w = '{mul: MUL_VY_DEC, op: OP_VX_DEC,  jmp: JMP_NEXT,   target: '0};
      4'd10: w = '{mul: MUL_NONE,   op: OP_VY_DEC,  jmp: JMP_NEXT,   target: '0};
      4'd11: w = '{mul: MUL_NONE,   op: OP_MOVE,    jmp: JMP_NEXT,   target: '0};
      4'd12: w = '{mul: MUL_NONE,   op: OP_FINISH,  jmp: JMP_NEXT,   target: '0};
      default: w = '{mul: MUL_NONE, op: OP_FINISH,  jmp: JMP_NEXT,   target: '0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jpm_seq.sv @@
// jpm_seq: step counter and microcode table lookup for the pointer mover
// depends on jpm_pkg
`default_nettype none

module jpm_seq
  import jpm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire seq_status_t status,
  output logic             busy,
  output ctrl_word_t       ctrl
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              taken;

  assign ctrl = ucode_rom(step_r);
  assign busy = busy_r;

  // jump decision
  always_comb begin
    case (ctrl.jmp)
      JMP_ALWAYS: taken = 1'b1;
      JMP_IDLE:   taken = !status.live;
      default:    taken = 1'b0;
    endcase
  end

  // step sequencing, finish step waits for a free result register
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (ctrl.op == OP_FINISH) begin
        if (!status.hold) busy_nxt = 1'b0;
      end else if (taken) begin
        step_nxt = ctrl.target;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/joystick_pointer_mover_core.sv @@
// joystick_pointer_mover_core: top level, shared multiplier datapath under microcode control
// depends on jpm_pkg and jpm_seq
//
// One input transfer is one tick of the stick: two Q1.15 axes and two button
// levels. Each tick yields exactly one result transfer with the cursor pixel,
// click pulses and the hover focus request.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, which the block
// does not enforce; indexes past the register list are ignored. Work per
// tick runs as a microcode program on one 18x32 multiplier, one product
// per step: a tick with a live axis takes 10 steps, an idle tick (velocity
// decay) takes 6. The result register loads on the last step, and in_tready
// rises in the same cycle as out_tvalid, so the next input can be taken then.
// in_tready is high whenever no tick is in work; a result waiting in the
// output register does not block the next input. If the receiver stalls,
// the next tick halts at its last step until the output register frees.
// Synchronous reset clears the registers to their defaults, places the
// cursor at 400,300 with zero velocity, and empties the output register.
`default_nettype none

module joystick_pointer_mover_core
  import jpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tdata: axis_x[15:0], axis_y[31:16], button_a[32], button_b[33], zero fill
  input  wire logic [IN_W-1:0]       in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: cursor_x[12:0], cursor_y[25:13], left_click[26], right_click[27],
  //        focus_fire[28], focus_x[41:29], focus_y[54:42], zero fill
  output logic [OUT_W-1:0]           out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [14:0] deadzone_r;
  logic [15:0] speed_slow_r, speed_fast_r;
  logic [12:0] view_w_r, view_h_r;
  logic [7:0]  move_lim_r, hover_dly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r   <= DEADZONE_RST;
      speed_slow_r <= SPEED_SLOW_RST;
      speed_fast_r <= SPEED_FAST_RST;
      view_w_r     <= VIEW_W_RST;
      view_h_r     <= VIEW_H_RST;
      move_lim_r   <= MOVE_LIM_RST;
      hover_dly_r  <= HOVER_DLY_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEADZONE:   deadzone_r   <= cfg_wdata[14:0];
        REG_SPEED_SLOW: speed_slow_r <= cfg_wdata;
        REG_SPEED_FAST: speed_fast_r <= cfg_wdata;
        REG_VIEW_W:     view_w_r     <= cfg_wdata[12:0];
        REG_VIEW_H:     view_h_r     <= cfg_wdata[12:0];
        REG_MOVE_LIM:   move_lim_r   <= cfg_wdata[7:0];
        REG_HOVER_DLY:  hover_dly_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic        busy;
  logic        in_xfer;
  ctrl_word_t  ctrl;
  seq_status_t status;
  logic        out_valid_r;

  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;

  jpm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_xfer),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  // input capture: magnitudes with the deadzone applied
  logic signed [16:0] ax_ext, ay_ext;
  logic [16:0]        ax_mag, ay_mag, mx_in, my_in;
  logic [16:0]        mx_r, my_r;
  logic               neg_x_r, neg_y_r, btn_a_r, btn_b_r;

  assign ax_ext = {in_tdata[15], in_tdata[15:0]};
  assign ay_ext = {in_tdata[31], in_tdata[31:16]};
  assign ax_mag = ax_ext[16] ? 17'(-ax_ext) : 17'(ax_ext);
  assign ay_mag = ay_ext[16] ? 17'(-ay_ext) : 17'(ay_ext);
  assign mx_in  = (ax_mag < {2'b00, deadzone_r}) ? '0 : ax_mag;
  assign my_in  = (ay_mag < {2'b00, deadzone_r}) ? '0 : ay_mag;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mx_r    <= mx_in;
      my_r    <= my_in;
      neg_x_r <= ax_ext[16];
      neg_y_r <= ay_ext[16];
      btn_a_r <= in_tdata[32];
      btn_b_r <= in_tdata[33];
    end
  end

  assign status.live = (mx_r != '0) || (my_r != '0);
  assign status.hold = out_valid_r && !out_tready;

  // shared multiplier with registered product
  logic signed [16:0] vel_x_r, vel_y_r;
  logic [30:0]        acc_r;
  logic [15:0]        speed_r;
  logic [16:0]        vx_mag, vy_mag, spd_diff;
  logic signed [17:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] prod_r;

  assign vx_mag   = vel_x_r[16] ? 17'(-vel_x_r) : 17'(vel_x_r);
  assign vy_mag   = vel_y_r[16] ? 17'(-vel_y_r) : 17'(vel_y_r);
  assign spd_diff = {1'b0, speed_fast_r} - {1'b0, speed_slow_r};

  always_comb begin
    case (ctrl.mul)
      MUL_MX_MX:  begin mul_a = {1'b0, mx_r};   mul_b = {15'd0, mx_r};         end
      MUL_MY_MY:  begin mul_a = {1'b0, my_r};   mul_b = {15'd0, my_r};         end
      MUL_D_M2:   begin mul_a = {spd_diff[16], spd_diff}; mul_b = {1'b0, acc_r}; end
      MUL_MX_SPD: begin mul_a = {1'b0, mx_r};   mul_b = {16'd0, speed_r};      end
      MUL_MY_SPD: begin mul_a = {1'b0, my_r};   mul_b = {16'd0, speed_r};      end
      MUL_VX_DEC: begin mul_a = {1'b0, vx_mag}; mul_b = {16'd0, DECAY_Q16};    end
      MUL_VY_DEC: begin mul_a = {1'b0, vy_mag}; mul_b = {16'd0, DECAY_Q16};    end
      default:    begin mul_a = '0;             mul_b = '0;                    end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // arithmetic on the product
  logic [31:0]        m2_sum;
  logic signed [19:0] spd_full;
  logic [16:0]        live_mag, dec_mag;
  logic signed [16:0] vel_live, vel_dec_x, vel_dec_y;

  assign m2_sum   = {1'b0, acc_r} + prod_r[31:0];
  assign spd_full = $signed({4'd0, speed_slow_r}) + $signed(prod_r[49:30]);
  assign live_mag = prod_r[31:15];
  assign dec_mag  = (prod_r[32:16] < SNAP_Q8) ? '0 : prod_r[32:16];
  assign vel_dec_x = vel_x_r[16] ? $signed(17'(-dec_mag)) : $signed(dec_mag);
  assign vel_dec_y = vel_y_r[16] ? $signed(17'(-dec_mag)) : $signed(dec_mag);

  // sign of the live velocity follows the axis of this step
  always_comb begin
    if (ctrl.op == OP_VY_LIVE) begin
      vel_live = neg_y_r ? $signed(17'(-live_mag)) : $signed(live_mag);
    end else begin
      vel_live = neg_x_r ? $signed(17'(-live_mag)) : $signed(live_mag);
    end
  end

  // position update with clamp to the view
  function automatic logic [20:0] move_clamp(input logic [20:0] pos,
                                             input logic signed [16:0] vel,
                                             input logic [12:0] view);
    logic signed [22:0] p;
    logic [20:0]        top;
    p   = $signed({2'b00, pos}) + 23'(vel);
    top = {view, 8'd0};
    if (p[22]) return '0;
    else if (p[21:0] > {1'b0, top}) return top;
    else return p[20:0];
  endfunction

  logic [20:0] pos_x_r, pos_y_r;

  // hover and click logic on the final step
  logic        last_a_r, last_b_r, anchor_seen_r;
  logic [12:0] anchor_x_r, anchor_y_r, pend_x_r, pend_y_r;
  logic [7:0]  hover_cnt_r, hover_cnt_nxt;
  logic [12:0] ix, iy, dx, dy;
  logic        resched, fire;
  logic        finish;

  assign ix      = pos_x_r[20:8];
  assign iy      = pos_y_r[20:8];
  assign dx      = (ix > anchor_x_r) ? ix - anchor_x_r : anchor_x_r - ix;
  assign dy      = (iy > anchor_y_r) ? iy - anchor_y_r : anchor_y_r - iy;
  assign resched = !anchor_seen_r || (dx > {5'd0, move_lim_r}) || (dy > {5'd0, move_lim_r});
  assign fire    = !resched && (hover_cnt_r == 8'd1);
  assign finish  = busy && (ctrl.op == OP_FINISH) && !status.hold;

  // zero delay acts as one tick
  always_comb begin
    hover_cnt_nxt = hover_cnt_r;
    if (resched) begin
      hover_cnt_nxt = (hover_dly_r == 8'd0) ? 8'd1 : hover_dly_r;
    end else if (hover_cnt_r != 8'd0) begin
      hover_cnt_nxt = hover_cnt_r - 8'd1;
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    if (busy) begin
      case (ctrl.op)
        OP_LD_ACC:  acc_r <= prod_r[30:0];
        OP_ADD_ACC: acc_r <= (m2_sum > {1'b0, ONE_Q30}) ? ONE_Q30 : m2_sum[30:0];
        OP_LD_SPD:  speed_r <= spd_full[15:0];
        default: ;
      endcase
    end
  end

  // tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r       <= POS_X_RST;
      pos_y_r       <= POS_Y_RST;
      vel_x_r       <= '0;
      vel_y_r       <= '0;
      last_a_r      <= 1'b0;
      last_b_r      <= 1'b0;
      anchor_seen_r <= 1'b0;
      anchor_x_r    <= '0;
      anchor_y_r    <= '0;
      hover_cnt_r   <= '0;
      pend_x_r      <= '0;
      pend_y_r      <= '0;
    end else if (busy) begin
      case (ctrl.op)
        OP_VX_LIVE: vel_x_r <= vel_live;
        OP_VY_LIVE: vel_y_r <= vel_live;
        OP_VX_DEC:  vel_x_r <= vel_dec_x;
        OP_VY_DEC:  vel_y_r <= vel_dec_y;
        OP_MOVE: begin
          pos_x_r <= move_clamp(pos_x_r, vel_x_r, view_w_r);
          pos_y_r <= move_clamp(pos_y_r, vel_y_r, view_h_r);
        end
        OP_FINISH: begin
          if (finish) begin
            last_a_r    <= btn_a_r;
            last_b_r    <= btn_b_r;
            hover_cnt_r <= hover_cnt_nxt;
            if (resched) begin
              anchor_seen_r <= 1'b1;
              anchor_x_r    <= ix;
              anchor_y_r    <= iy;
              pend_x_r      <= ix;
              pend_y_r      <= iy;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {1'b0,
                     fire ? pend_y_r : 13'd0,
                     fire ? pend_x_r : 13'd0,
                     fire,
                     btn_b_r && !last_b_r,
                     btn_a_r && !last_a_r,
                     iy,
                     ix};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/jpm_checker.sv @@
// jpm_checker: port-level assertions for the pointer mover, bound to the top level
// depends on jpm_pkg and joystick_pointer_mover_core
`default_nettype none

module jpm_checker
  import jpm_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tvalid,
  input wire logic             out_tready
);

  // result register empty after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one tick in work at a time: an input transfer closes the input side
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a tick is in work");

  // focus coordinates are zero unless focus fires (focus_fire is bit 28)
  a_focus_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[28]) |-> (out_tdata[54:29] == '0))
    else $error("focus coordinates without focus request");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind joystick_pointer_mover_core jpm_checker u_jpm_checker (.*);

`default_nettype wire

@@ bench/joystick_pointer_mover_core_tb.sv @@
// joystick_pointer_mover_core_tb: self-checking bench for the joystick pointer mover core
// drives stick ticks and register writes, predicts each cursor report or uses a fixed one, compares each transfer
// depends on jpm_pkg and joystick_pointer_mover_core
`default_nettype none

module joystick_pointer_mover_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jpm_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_TICKS   = 100;
  localparam longint Q30_ONE   = 64'd1 << 30;
  localparam longint DECAY_055 = 64'd36045;
  localparam int SNAP_HALF_PX  = 128;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 3'd7;

  typedef struct {
    logic [12:0] cursor_x;
    logic [12:0] cursor_y;
    logic        left_click;
    logic        right_click;
    logic        focus_fire;
    logic [12:0] focus_x;
    logic [12:0] focus_y;
  } cursor_report_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic signed [15:0]     ax;
    logic signed [15:0]     ay;
    logic                   ba;
    logic                   bb;
    bit                     has_fixed;
    cursor_report_t         fixed;
  } stim_row_t;

  typedef enum logic [1:0] {
    GEST_REST    = 2'd0,
    GEST_HOLD    = 2'd1,
    GEST_SWEEP   = 2'd2,
    GEST_EXTREME = 2'd3
  } gesture_t;

  // dut ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of registers and pointer state
  logic [14:0]        dz_reg;
  logic [15:0]        slow_reg, fast_reg;
  logic [12:0]        view_w_reg, view_h_reg;
  logic [7:0]         move_lim_reg, hover_dly_reg;
  logic [20:0]        pos_x, pos_y;
  logic signed [16:0] vel_x, vel_y;
  logic               prev_a, prev_b, anchor_valid;
  logic [12:0]        anchor_x, anchor_y, pend_x, pend_y;
  logic [7:0]         hover_left;

  cursor_report_t expected_reports[$];
  stim_row_t      directed_rows[$];
  int             mismatches = 0;
  int             cycle_count = 0;
  bit             calm = 1'b0;
  int             tx_quiet = 0;
  int             rx_quiet = 0;
  int             rx_stall = 0;
  logic           btn_a = 1'b0;
  logic           btn_b = 1'b0;

  joystick_pointer_mover_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("joystick_pointer_mover_core verification failed");
      $finish;
    end
  end

  function automatic void reset_pointer_model();
    dz_reg = DEADZONE_RST;
    slow_reg = SPEED_SLOW_RST;
    fast_reg = SPEED_FAST_RST;
    view_w_reg = VIEW_W_RST;
    view_h_reg = VIEW_H_RST;
    move_lim_reg = MOVE_LIM_RST;
    hover_dly_reg = HOVER_DLY_RST;
    pos_x = 21'(400 * 256);
    pos_y = 21'(300 * 256);
    vel_x = '0;
    vel_y = '0;
    prev_a = 1'b0;
    prev_b = 1'b0;
    anchor_valid = 1'b0;
    anchor_x = '0;
    anchor_y = '0;
    pend_x = '0;
    pend_y = '0;
    hover_left = '0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DEADZONE:   dz_reg = val[14:0];
      REG_SPEED_SLOW: slow_reg = val;
      REG_SPEED_FAST: fast_reg = val;
      REG_VIEW_W:     view_w_reg = val[12:0];
      REG_VIEW_H:     view_h_reg = val[12:0];
      REG_MOVE_LIM:   move_lim_reg = val[7:0];
      REG_HOVER_DLY:  hover_dly_reg = val[7:0];
      default: ;
    endcase
  endfunction

  // velocity from deflection, magnitude truncated toward zero
  function automatic int axis_velocity(input int axis, input longint spd);
    longint mag;
    mag = (axis < 0) ? -axis : axis;
    mag = (mag * spd) >> 15;
    return (axis < 0) ? -int'(mag) : int'(mag);
  endfunction

  // idle stick: scale by 0.55 and snap under half a pixel
  function automatic int decayed_velocity(input int v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * DECAY_055) >> 16;
    if (mag < SNAP_HALF_PX) return 0;
    return (v < 0) ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [20:0] clamped_position(input logic [20:0] pos, input int v,
                                                   input logic [12:0] view);
    int p;
    int top;
    p = int'(pos) + v;
    top = int'(view) << 8;
    if (p < 0) p = 0;
    if (p > top) p = top;
    return 21'(p);
  endfunction

  function automatic int pixel_distance(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // one tick of the pointer: motion, clicks and hover focus
  function automatic cursor_report_t advance_cursor(input logic signed [15:0] ax_in,
                                                    input logic signed [15:0] ay_in,
                                                    input logic ba, input logic bb);
    int ax, ay, mx, my, ix, iy;
    longint m2, spd;
    cursor_report_t r;
    ax = int'(ax_in);
    ay = int'(ay_in);
    mx = (ax < 0) ? -ax : ax;
    my = (ay < 0) ? -ay : ay;
    if (mx < int'(dz_reg)) begin
      ax = 0;
      mx = 0;
    end
    if (my < int'(dz_reg)) begin
      ay = 0;
      my = 0;
    end
    if (mx != 0 || my != 0) begin
      m2 = longint'(mx) * mx + longint'(my) * my;
      if (m2 > Q30_ONE) m2 = Q30_ONE;
      spd = (longint'(slow_reg) * (Q30_ONE - m2) + longint'(fast_reg) * m2) >> 30;
      vel_x = 17'(axis_velocity(ax, spd));
      vel_y = 17'(axis_velocity(ay, spd));
    end else begin
      vel_x = 17'(decayed_velocity(int'(vel_x)));
      vel_y = 17'(decayed_velocity(int'(vel_y)));
    end
    pos_x = clamped_position(pos_x, int'(vel_x), view_w_reg);
    pos_y = clamped_position(pos_y, int'(vel_y), view_h_reg);
    ix = int'(pos_x[20:8]);
    iy = int'(pos_y[20:8]);

    r.left_click = ba && !prev_a;
    r.right_click = bb && !prev_b;
    prev_a = ba;
    prev_b = bb;

    // hover: a large move re-anchors and reloads the countdown
    r.focus_fire = 1'b0;
    if (!anchor_valid || pixel_distance(ix, int'(anchor_x)) > int'(move_lim_reg) ||
        pixel_distance(iy, int'(anchor_y)) > int'(move_lim_reg)) begin
      anchor_valid = 1'b1;
      anchor_x = 13'(ix);
      anchor_y = 13'(iy);
      pend_x = 13'(ix);
      pend_y = 13'(iy);
      hover_left = (hover_dly_reg != 0) ? hover_dly_reg : 8'd1;
    end else if (hover_left != 0) begin
      hover_left--;
      if (hover_left == 0) r.focus_fire = 1'b1;
    end

    r.cursor_x = 13'(ix);
    r.cursor_y = 13'(iy);
    r.focus_x = r.focus_fire ? pend_x : 13'd0;
    r.focus_y = r.focus_fire ? pend_y : 13'd0;
    return r;
  endfunction

  // directed table rows
  function automatic stim_row_t tick_row(input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic ba, input logic bb);
    stim_row_t s;
    s = '{default: '0};
    s.ax = ax;
    s.ay = ay;
    s.ba = ba;
    s.bb = bb;
    return s;
  endfunction

  function automatic stim_row_t known_row(input logic signed [15:0] ax,
                                          input logic signed [15:0] ay,
                                          input logic ba, input logic bb,
                                          input int cx, input int cy,
                                          input logic lc, input logic rc);
    stim_row_t s;
    s = tick_row(ax, ay, ba, bb);
    s.has_fixed = 1'b1;
    s.fixed = '{cursor_x: 13'(cx), cursor_y: 13'(cy), left_click: lc, right_click: rc,
                focus_fire: 1'b0, focus_x: 13'd0, focus_y: 13'd0};
    return s;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  // one stick tick on the input channel, prediction at the transfer
  task automatic send_tick(input logic signed [15:0] ax, input logic signed [15:0] ay,
                           input logic ba, input logic bb,
                           input bit has_fixed, input cursor_report_t fixed);
    cursor_report_t r;
    in_tdata <= {6'b0, bb, ba, ay, ax};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = advance_cursor(ax, ay, ba, bb);
    expected_reports.push_back(has_fixed ? fixed : r);
    if (tx_quiet > 0) tx_quiet--;
    if (!calm && tx_quiet == 0 && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold the sender until every report is back
  task automatic drain_ticks();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    drain_ticks();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_registers(input logic [15:0] dz, input logic [15:0] slow,
                                     input logic [15:0] fast, input logic [15:0] vw,
                                     input logic [15:0] vh, input logic [15:0] lim,
                                     input logic [15:0] dly);
    write_register(REG_DEADZONE, dz);
    write_register(REG_SPEED_SLOW, slow);
    write_register(REG_SPEED_FAST, fast);
    write_register(REG_VIEW_W, vw);
    write_register(REG_VIEW_H, vh);
    write_register(REG_MOVE_LIM, lim);
    write_register(REG_HOVER_DLY, dly);
  endtask

  function automatic logic signed [15:0] extreme_axis();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -16'sd32767;
      3: return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // random gestures: rests, held deflections, sweeps and extremes
  task automatic run_random_phase(input int n_ticks);
    gesture_t kind;
    int left;
    logic signed [15:0] hx, hy, ax, ay;
    cursor_report_t blank;
    kind = GEST_REST;
    left = 0;
    hx = '0;
    hy = '0;
    blank = '{default: '0};
    for (int i = 0; i < n_ticks; i++) begin
      if (left == 0) begin
        kind = gesture_t'($urandom_range(0, 3));
        case (kind)
          GEST_REST:  left = $urandom_range(3, 40);
          GEST_HOLD: begin
            left = $urandom_range(2, 15);
            hx = 16'($urandom);
            hy = ($urandom_range(0, 1) == 0) ? 16'sd0 : 16'($urandom);
          end
          GEST_SWEEP: left = $urandom_range(1, 10);
          default: begin
            left = $urandom_range(1, 6);
            hx = extreme_axis();
            hy = extreme_axis();
          end
        endcase
        if ($urandom_range(0, 3) == 0) tx_quiet = $urandom_range(10, 40);
      end
      left--;
      case (kind)
        GEST_REST: begin
          if ($urandom_range(0, 2) == 0) begin
            ax = 16'(int'($urandom_range(0, 600)) - 300);
            ay = 16'(int'($urandom_range(0, 600)) - 300);
          end else begin
            ax = '0;
            ay = '0;
          end
        end
        GEST_SWEEP: begin
          ax = 16'($urandom);
          ay = 16'($urandom);
        end
        default: begin
          ax = hx;
          ay = hy;
        end
      endcase
      if ($urandom_range(0, 5) == 0) btn_a = ~btn_a;
      if ($urandom_range(0, 5) == 0) btn_b = ~btn_b;
      if (!calm && $urandom_range(0, 59) == 0) drain_ticks();
      send_tick(ax, ay, btn_a, btn_b, 1'b0, blank);
    end
  endtask

  // receiver back-pressure in bursts, with quiet stretches
  always @(posedge clk) begin
    if (rx_quiet > 0) rx_quiet--;
    if (!calm && rx_quiet == 0 && rx_stall == 0 && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) rx_quiet = $urandom_range(20, 80);
    end
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    cursor_report_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result transfer: %h", out_tdata);
        mismatches++;
      end else begin
        e = expected_reports.pop_front();
        check_field("cursor_x", e.cursor_x, out_tdata[12:0]);
        check_field("cursor_y", e.cursor_y, out_tdata[25:13]);
        check_field("left_click", e.left_click, out_tdata[26]);
        check_field("right_click", e.right_click, out_tdata[27]);
        check_field("focus_fire", e.focus_fire, out_tdata[28]);
        check_field("focus_x", e.focus_x, out_tdata[41:29]);
        check_field("focus_y", e.focus_y, out_tdata[54:42]);
      end
    end
  end

  initial begin
    stim_row_t row;
    reset_pointer_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: after reset, clicks, extremes, deadzone edges
    directed_rows.push_back(known_row(16'sd0, 16'sd0, 1'b0, 1'b0, 400, 300, 1'b0, 1'b0));
    directed_rows.push_back(known_row(16'sd0, 16'sd0, 1'b1, 1'b0, 400, 300, 1'b1, 1'b0));
    directed_rows.push_back(known_row(16'sd0, 16'sd0, 1'b1, 1'b1, 400, 300, 1'b0, 1'b1));
    directed_rows.push_back(tick_row(16'sd32767, 16'sd0, 1'b0, 1'b0));
    directed_rows.push_back(tick_row(-16'sd32768, -16'sd32768, 1'b0, 1'b1));
    directed_rows.push_back(tick_row(16'sd4914, -16'sd4914, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(16'sd4915, -16'sd4915, 1'b0, 1'b0));
    repeat (3) directed_rows.push_back(tick_row(16'sd0, 16'sd0, 1'b0, 1'b0));
    // zero hover delay and zero move limit
    directed_rows.push_back(reg_row(REG_HOVER_DLY, 16'd0));
    directed_rows.push_back(reg_row(REG_MOVE_LIM, 16'd0));
    repeat (4) directed_rows.push_back(tick_row(16'sd0, 16'sd0, 1'b0, 1'b0));
    // fast below slow
    directed_rows.push_back(reg_row(REG_SPEED_SLOW, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_SPEED_FAST, 16'h0000));
    directed_rows.push_back(tick_row(16'sd32767, -16'sd32768, 1'b1, 1'b1));
    directed_rows.push_back(tick_row(16'sd100, 16'sd16384, 1'b0, 1'b0));
    // empty view clamps to the origin
    directed_rows.push_back(reg_row(REG_VIEW_W, 16'd0));
    directed_rows.push_back(reg_row(REG_VIEW_H, 16'd0));
    directed_rows.push_back(tick_row(-16'sd32768, 16'sd32767, 1'b0, 1'b0));
    // write past the register list is dropped
    directed_rows.push_back(reg_row(REG_PAST_END, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_VIEW_W, 16'h1FFF));
    directed_rows.push_back(reg_row(REG_VIEW_H, 16'h1FFF));
    directed_rows.push_back(reg_row(REG_DEADZONE, 16'hFFFF));
    directed_rows.push_back(tick_row(-16'sd32768, 16'sd32767, 1'b0, 1'b0));
    directed_rows.push_back(tick_row(16'sd32766, -16'sd32767, 1'b0, 1'b0));
    directed_rows.push_back(reg_row(REG_DEADZONE, 16'd0));
    directed_rows.push_back(tick_row(16'sd1, -16'sd1, 1'b1, 1'b0));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_register(row.idx, row.val);
      else send_tick(row.ax, row.ay, row.ba, row.bb, row.has_fixed, row.fixed);
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: write_all_registers(16'(DEADZONE_RST), SPEED_SLOW_RST, SPEED_FAST_RST,
                               16'(VIEW_W_RST), 16'(VIEW_H_RST), 16'(MOVE_LIM_RST),
                               16'(HOVER_DLY_RST));
        1: write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1FFF, 16'h1FFF,
                               16'h00FF, 16'h00FF);
        2: write_all_registers(16'h0000, 16'h0000, 16'hFFFF, 16'($urandom_range(1, 40)),
                               16'($urandom_range(1, 40)), 16'h0000, 16'h0000);
        default: write_all_registers(
            ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000)),
            ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096)),
            ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384)),
            ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 60)) : 16'($urandom),
            ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 60)) : 16'($urandom),
            16'($urandom_range(0, 16)), 16'($urandom_range(0, 30)));
      endcase
      calm = (ph == PHASE_COUNT - 1);
      run_random_phase(PHASE_TICKS);
    end

    // wind down
    drain_ticks();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("joystick_pointer_mover_core verification clean");
    end else begin
      $display("joystick_pointer_mover_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/jpm_pkg.sv
hw/rtl/jpm_seq.sv
hw/rtl/joystick_pointer_mover_core.sv
hw/rtl/jpm_checker.sv
bench/joystick_pointer_mover_core_tb.sv
